### hw/rtl/sfd_pkg.sv
// Shared types and constants for the serial frame decoder.
// No dependencies; imported by every other file in hw/rtl.
package sfd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] MIN_LENGTH  = 8'd9;

	localparam logic [7:0]  MAX_LENGTH_RESET   = 8'h50;
	localparam logic [15:0] DATA_COMMAND_RESET = 16'h800B;

	// body byte counts at which the command bytes and the first payload byte arrive
	localparam logic [7:0] CMD_HIGH_POS  = 8'd6;
	localparam logic [7:0] CMD_LOW_POS   = 8'd7;
	localparam logic [7:0] PAYLOAD_START = 8'd8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DATA_COMMAND = 2'd1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [15:0] command;
		logic        to_data_channel;
		logic        frame_ok;
		logic [7:0]  payload_length;
	} result_t;

endpackage

### hw/rtl/sfd_parser.sv
// Frame hunt state machine: sync, length check, command capture and XOR check.
// Depends on sfd_pkg for constants and the result_t type.
module sfd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            max_length,
	input  logic [15:0]           data_command,
	output logic                  res_valid,
	output sfd_pkg::result_t      res
);
	import sfd_pkg::*;

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_SYNC2  = 2'd1;
	localparam logic [1:0] PH_LENGTH = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  frame_length_q, frame_length_d;
	logic [7:0]  byte_position_q, byte_position_d;
	logic [7:0]  running_xor_q, running_xor_d;
	logic [15:0] current_command_q, current_command_d;

	logic [7:0] k;
	logic [7:0] xor_next;
	logic       is_end;

	assign k        = byte_position_q + 8'd1;
	assign xor_next = running_xor_q ^ rx_byte;
	assign is_end   = (k == frame_length_q - 8'd1);

	always_comb begin
		phase_d           = phase_q;
		frame_length_d    = frame_length_q;
		byte_position_d   = byte_position_q;
		running_xor_d     = running_xor_q;
		current_command_d = current_command_q;
		res_valid         = 1'b0;
		res.kind            = KIND_PAYLOAD;
		res.payload_byte    = 8'd0;
		res.command         = current_command_q;
		res.to_data_channel = (current_command_q == data_command);
		res.frame_ok        = 1'b0;
		res.payload_length  = frame_length_q - MIN_LENGTH;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d = PH_LENGTH;
				end else if (rx_byte != SYNC_FIRST) begin
					phase_d         = PH_HUNT;
					byte_position_d = 8'd0;
				end
			end
			PH_LENGTH: begin
				if (rx_byte < MIN_LENGTH || rx_byte > max_length) begin
					phase_d         = PH_HUNT;
					byte_position_d = 8'd0;
				end else begin
					frame_length_d    = rx_byte;
					running_xor_d     = rx_byte;
					byte_position_d   = 8'd0;
					current_command_d = 16'd0;
					phase_d           = PH_BODY;
				end
			end
			PH_BODY: begin
				byte_position_d = k;
				running_xor_d   = xor_next;
				if (is_end) begin
					res_valid       = 1'b1;
					res.kind        = KIND_END;
					res.frame_ok    = (xor_next == 8'd0);
					phase_d         = PH_HUNT;
					byte_position_d = 8'd0;
				end else if (k == CMD_HIGH_POS) begin
					current_command_d = {rx_byte, current_command_q[7:0]};
				end else if (k == CMD_LOW_POS) begin
					current_command_d = {current_command_q[15:8], rx_byte};
				end else if (k >= PAYLOAD_START) begin
					res_valid        = 1'b1;
					res.payload_byte = rx_byte;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
		if (!go) res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HUNT;
			frame_length_q    <= 8'd0;
			byte_position_q   <= 8'd0;
			running_xor_q     <= 8'd0;
			current_command_q <= 16'd0;
		end else if (go) begin
			phase_q           <= phase_d;
			frame_length_q    <= frame_length_d;
			byte_position_q   <= byte_position_d;
			running_xor_q     <= running_xor_d;
			current_command_q <= current_command_d;
		end
	end

endmodule

### hw/rtl/sfd_out_queue.sv
// Two-entry result queue that decouples the parser from a stalling receiver.
// Depends on sfd_pkg for result_t.
module sfd_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfd_pkg::result_t push_data,
	input  logic             pop_ready,
	output logic             pop_valid,
	output sfd_pkg::result_t pop_data,
	output logic             full
);
	import sfd_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/serial_frame_decoder.sv
// Top level of the serial frame decoder: input register, config registers,
// parser and result queue. Depends on sfd_pkg, sfd_parser, sfd_out_queue.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transaction. Output channel (out_valid/out_ready) gives payload results
//   (kind=0) as frame bytes 10.. arrive, and one end result (kind=1) at the
//   check byte carrying frame_ok and payload_length. Drop a frame's payload
//   when its end result shows frame_ok=0.
//   A byte accepted passes through the input register, then the parser into
//   the result queue. Throughput: one byte per cycle while the queue has
//   room, set by the parser update between input register and queue.
//   Receiver stall: the two-entry queue absorbs results; in_ready falls once
//   the queue is full and the input register holds a byte.
//   Reset: hunt state cleared, max_length=80, data_command=0x800B, queue
//   empty. Write cfg_we/cfg_index/cfg_data only while idle; indexes beyond
//   the register list are ignored.
module serial_frame_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [7:0]                      payload_byte,
	output logic [15:0]                     command,
	output logic                            to_data_channel,
	output logic                            frame_ok,
	output logic [7:0]                      payload_length
);
	import sfd_pkg::*;

	logic [7:0]  max_length_q;
	logic [15:0] data_command_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        q_full;
	logic        go;
	logic        res_valid;
	result_t     res;
	result_t     out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q   <= MAX_LENGTH_RESET;
			data_command_q <= DATA_COMMAND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LENGTH:   max_length_q   <= cfg_data[7:0];
				REG_DATA_COMMAND: data_command_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the held byte whenever the queue has room
	assign go       = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	sfd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.rx_byte      (byte_s1),
		.max_length   (max_length_q),
		.data_command (data_command_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	sfd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (out_res),
		.full      (q_full)
	);

	assign kind            = out_res.kind;
	assign payload_byte    = out_res.payload_byte;
	assign command         = out_res.command;
	assign to_data_channel = out_res.to_data_channel;
	assign frame_ok        = out_res.frame_ok;
	assign payload_length  = out_res.payload_length;

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> payload_byte == 8'd0)
		else $error("end result carries a payload byte");

	a_payload_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PAYLOAD |-> !frame_ok)
		else $error("payload result flagged frame_ok");

	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !out_ready |=> valid_s1)
		else $error("input stage lost a byte during stall");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !q_full)
		else $error("result pushed into a full queue");

endmodule
